>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file tcp_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked concurrent assertion, disabled while reset is asserted
`define TCP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked from the cycle after the antecedent
`define TCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tcp_pkg.sv
// widths, types and constants of the triangle centre point block
// no dependencies
package tcp_pkg;

  localparam int CoordBits = 12;
  localparam int FracBits  = 16;
  localparam int InW       = 12;
  localparam int CenW      = 28;
  localparam int PtW       = 54;

  localparam int DW  = CoordBits + 1;
  localparam int SW  = CoordBits + 2;
  localparam int CW2 = 2 * DW + 1;
  localparam int PW  = CW2 + DW;
  localparam int HW  = 3 * DW + 3;
  localparam int ZW  = 2 * DW + 3;
  localparam int NW  = HW + FracBits;
  localparam int QXW = ((NW > PtW) ? NW : PtW) + 1;
  localparam int CMW = SW + FracBits;
  localparam int CVW = (CMW + 1 > CenW) ? CMW + 1 : CenW;

  localparam int Lanes = 4;
  localparam int LaneOx = 0;
  localparam int LaneOy = 1;
  localparam int LaneCx = 2;
  localparam int LaneCy = 3;

  localparam logic [31:0] Recip3      = 32'hAAAA_AAAB;
  localparam int          Recip3Shift = 33;

  localparam logic signed [CVW-1:0] CenMax = {{(CVW - CenW + 1){1'b0}}, {(CenW - 1){1'b1}}};
  localparam logic signed [CVW-1:0] CenMin = ~CenMax;
  localparam logic signed [QXW-1:0] PtMax  = {{(QXW - PtW + 1){1'b0}}, {(PtW - 1){1'b1}}};
  localparam logic signed [QXW-1:0] PtMin  = ~PtMax;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [ZW-1:0] rem;
    logic [ZW-1:0] den;
    logic          neg;
    logic          zero;
  } lane_t;

endpackage

>>> hw/rtl/triangle_center_points_top.sv
// Pipeline from input transaction to result: three arithmetic stages, one divider
// set-up stage, 58 restoring divider stages and one output stage.
// Throughput: one triangle per cycle while out_ready_i does not stall a full output stage.
// Reset: rst_ni clears the stage valid bits only; the datapath registers are not reset.
// Depends on tcp_pkg.
module triangle_center_points_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic        [tcp_pkg::InW-1:0] ax_i,
  input  logic        [tcp_pkg::InW-1:0] ay_i,
  input  logic        [tcp_pkg::InW-1:0] bx_i,
  input  logic        [tcp_pkg::InW-1:0] by_i,
  input  logic        [tcp_pkg::InW-1:0] cx_i,
  input  logic        [tcp_pkg::InW-1:0] cy_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [tcp_pkg::CenW-1:0] centroid_x_o,
  output logic signed [tcp_pkg::CenW-1:0] centroid_y_o,
  output logic signed [tcp_pkg::PtW-1:0]  ortho_x_o,
  output logic signed [tcp_pkg::PtW-1:0]  ortho_y_o,
  output logic                            ortho_valid_o,
  output logic signed [tcp_pkg::PtW-1:0]  circum_x_o,
  output logic signed [tcp_pkg::PtW-1:0]  circum_y_o,
  output logic                            circum_valid_o
);

  logic en;
  logic v1_q, v2_q, v3_q, vo_q;
  logic vd_q [tcp_pkg::NW+1];

  // stage 1
  logic signed [tcp_pkg::CoordBits-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [tcp_pkg::CoordBits-1:0] ax_s, ay_s, bx_s, by_s, cx_s, cy_s;
  logic signed [tcp_pkg::DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, sbx_q, sby_q, sax_q, say_q;
  logic signed [tcp_pkg::SW-1:0] sx_q, sy_q;

  // stage 2
  logic signed [tcp_pkg::CW2-1:0] c1o_d, c2o_d, c1c_d, c2c_d;
  logic signed [tcp_pkg::CW2-1:0] c1o_q, c2o_q, c1c_q, c2c_q;
  logic signed [tcp_pkg::ZW-1:0]  zo_d, zo_q;
  logic signed [tcp_pkg::DW-1:0]  e1x_q, e1y_q, e2x_q, e2y_q;
  logic        [tcp_pkg::SW-1:0]  mx, my;
  logic        [31:0]             xx, xy;
  logic        [63:0]             cpx_d, cpy_d, cpx_q, cpy_q;
  logic                           cnx_q, cny_q;

  // stage 3
  logic signed [tcp_pkg::PW-1:0]  po0, po1, po2, po3, pc0, pc1, pc2, pc3;
  logic signed [tcp_pkg::HW-1:0]  h0o_d, h1o_d, h0c_d, h1c_d;
  logic signed [tcp_pkg::HW-1:0]  h0o_q, h1o_q, h0c_q, h1c_q;
  logic signed [tcp_pkg::ZW-1:0]  zo3_q, zc3_q;
  logic        [tcp_pkg::CMW-1:0] cqx, cqy;
  logic signed [tcp_pkg::CVW-1:0] cvx, cvy;
  logic signed [tcp_pkg::CenW-1:0] cenx_d, ceny_d, cenx_q, ceny_q;

  // divider pipeline
  tcp_pkg::lane_t dv_q [tcp_pkg::NW+1][tcp_pkg::Lanes];
  tcp_pkg::lane_t dv_d [tcp_pkg::NW+1][tcp_pkg::Lanes];
  logic signed [tcp_pkg::CenW-1:0] dcx_q [tcp_pkg::NW+1];
  logic signed [tcp_pkg::CenW-1:0] dcy_q [tcp_pkg::NW+1];
  logic signed [tcp_pkg::HW-1:0]   hsel [tcp_pkg::Lanes];
  logic signed [tcp_pkg::ZW-1:0]   zsel [tcp_pkg::Lanes];
  logic signed [tcp_pkg::PtW-1:0]  pt_d [tcp_pkg::Lanes];
  logic signed [tcp_pkg::PtW-1:0]  pt_q [tcp_pkg::Lanes];
  logic                            zero_q;

  assign en         = out_ready_i | ~vo_q;
  assign in_ready_o = en;

  assign ax_s = ax_i[tcp_pkg::CoordBits-1:0];
  assign ay_s = ay_i[tcp_pkg::CoordBits-1:0];
  assign bx_s = bx_i[tcp_pkg::CoordBits-1:0];
  assign by_s = by_i[tcp_pkg::CoordBits-1:0];
  assign cx_s = cx_i[tcp_pkg::CoordBits-1:0];
  assign cy_s = cy_i[tcp_pkg::CoordBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= tcp_pkg::NW; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      vd_q[0]  <= v3_q;
      for (int k = 0; k < tcp_pkg::NW; k++) begin
        vd_q[k+1] <= vd_q[k];
      end
      vo_q     <= vd_q[tcp_pkg::NW];
    end
  end

  // stage 1: sums and differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= ax_s;
      ay_q  <= ay_s;
      bx_q  <= bx_s;
      by_q  <= by_s;
      d1x_q <= tcp_pkg::DW'(bx_s) - tcp_pkg::DW'(cx_s);
      d1y_q <= tcp_pkg::DW'(by_s) - tcp_pkg::DW'(cy_s);
      d2x_q <= tcp_pkg::DW'(ax_s) - tcp_pkg::DW'(cx_s);
      d2y_q <= tcp_pkg::DW'(ay_s) - tcp_pkg::DW'(cy_s);
      sbx_q <= tcp_pkg::DW'(bx_s) + tcp_pkg::DW'(cx_s);
      sby_q <= tcp_pkg::DW'(by_s) + tcp_pkg::DW'(cy_s);
      sax_q <= tcp_pkg::DW'(ax_s) + tcp_pkg::DW'(cx_s);
      say_q <= tcp_pkg::DW'(ay_s) + tcp_pkg::DW'(cy_s);
      sx_q  <= tcp_pkg::SW'(ax_s) + tcp_pkg::SW'(bx_s) + tcp_pkg::SW'(cx_s);
      sy_q  <= tcp_pkg::SW'(ay_s) + tcp_pkg::SW'(by_s) + tcp_pkg::SW'(cy_s);
    end
  end

  // stage 2: line offsets, homogeneous z, centroid reciprocal product
  always_comb begin
    c1o_d = tcp_pkg::CW2'(ax_q) * tcp_pkg::CW2'(d1x_q)
          + tcp_pkg::CW2'(ay_q) * tcp_pkg::CW2'(d1y_q);
    c2o_d = tcp_pkg::CW2'(bx_q) * tcp_pkg::CW2'(d2x_q)
          + tcp_pkg::CW2'(by_q) * tcp_pkg::CW2'(d2y_q);
    c1c_d = tcp_pkg::CW2'(sbx_q) * tcp_pkg::CW2'(d1x_q)
          + tcp_pkg::CW2'(sby_q) * tcp_pkg::CW2'(d1y_q);
    c2c_d = tcp_pkg::CW2'(sax_q) * tcp_pkg::CW2'(d2x_q)
          + tcp_pkg::CW2'(say_q) * tcp_pkg::CW2'(d2y_q);
    zo_d  = tcp_pkg::ZW'(d1x_q) * tcp_pkg::ZW'(d2y_q)
          - tcp_pkg::ZW'(d1y_q) * tcp_pkg::ZW'(d2x_q);
    mx    = sx_q[tcp_pkg::SW-1] ? tcp_pkg::SW'(-sx_q) : tcp_pkg::SW'(sx_q);
    my    = sy_q[tcp_pkg::SW-1] ? tcp_pkg::SW'(-sy_q) : tcp_pkg::SW'(sy_q);
    xx    = 32'(mx) << tcp_pkg::FracBits;
    xy    = 32'(my) << tcp_pkg::FracBits;
    cpx_d = xx * tcp_pkg::Recip3;
    cpy_d = xy * tcp_pkg::Recip3;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1o_q <= c1o_d;
      c2o_q <= c2o_d;
      c1c_q <= c1c_d;
      c2c_q <= c2c_d;
      zo_q  <= zo_d;
      e1x_q <= d1x_q;
      e1y_q <= d1y_q;
      e2x_q <= d2x_q;
      e2y_q <= d2y_q;
      cpx_q <= cpx_d;
      cpy_q <= cpy_d;
      cnx_q <= sx_q[tcp_pkg::SW-1];
      cny_q <= sy_q[tcp_pkg::SW-1];
    end
  end

  // stage 3: crossing point numerators, centroid sign and clamp
  always_comb begin
    po0 = c1o_q * e2y_q;
    po1 = e1y_q * c2o_q;
    po2 = e1x_q * c2o_q;
    po3 = c1o_q * e2x_q;
    pc0 = c1c_q * e2y_q;
    pc1 = e1y_q * c2c_q;
    pc2 = e1x_q * c2c_q;
    pc3 = c1c_q * e2x_q;
    h0o_d = tcp_pkg::HW'(po0) - tcp_pkg::HW'(po1);
    h1o_d = tcp_pkg::HW'(po2) - tcp_pkg::HW'(po3);
    h0c_d = (tcp_pkg::HW'(pc0) - tcp_pkg::HW'(pc1)) <<< 1;
    h1c_d = (tcp_pkg::HW'(pc2) - tcp_pkg::HW'(pc3)) <<< 1;
    cqx   = tcp_pkg::CMW'(cpx_q >> tcp_pkg::Recip3Shift);
    cqy   = tcp_pkg::CMW'(cpy_q >> tcp_pkg::Recip3Shift);
    cvx   = cnx_q ? -tcp_pkg::CVW'(cqx) : tcp_pkg::CVW'(cqx);
    cvy   = cny_q ? -tcp_pkg::CVW'(cqy) : tcp_pkg::CVW'(cqy);
    if (cvx > tcp_pkg::CenMax) begin
      cenx_d = tcp_pkg::CenW'(tcp_pkg::CenMax);
    end else if (cvx < tcp_pkg::CenMin) begin
      cenx_d = tcp_pkg::CenW'(tcp_pkg::CenMin);
    end else begin
      cenx_d = tcp_pkg::CenW'(cvx);
    end
    if (cvy > tcp_pkg::CenMax) begin
      ceny_d = tcp_pkg::CenW'(tcp_pkg::CenMax);
    end else if (cvy < tcp_pkg::CenMin) begin
      ceny_d = tcp_pkg::CenW'(tcp_pkg::CenMin);
    end else begin
      ceny_d = tcp_pkg::CenW'(cvy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h0o_q  <= h0o_d;
      h1o_q  <= h1o_d;
      h0c_q  <= h0c_d;
      h1c_q  <= h1c_d;
      zo3_q  <= zo_q;
      zc3_q  <= zo_q <<< 2;
      cenx_q <= cenx_d;
      ceny_q <= ceny_d;
    end
  end

  // divider set-up and restoring divider stages
  always_comb begin
    hsel[tcp_pkg::LaneOx] = h0o_q;
    hsel[tcp_pkg::LaneOy] = h1o_q;
    hsel[tcp_pkg::LaneCx] = h0c_q;
    hsel[tcp_pkg::LaneCy] = h1c_q;
    zsel[tcp_pkg::LaneOx] = zo3_q;
    zsel[tcp_pkg::LaneOy] = zo3_q;
    zsel[tcp_pkg::LaneCx] = zc3_q;
    zsel[tcp_pkg::LaneCy] = zc3_q;
    for (int l = 0; l < tcp_pkg::Lanes; l++) begin
      dv_d[0][l].num  = {(hsel[l][tcp_pkg::HW-1] ? tcp_pkg::HW'(-hsel[l])
                                                 : tcp_pkg::HW'(hsel[l])),
                         {tcp_pkg::FracBits{1'b0}}};
      dv_d[0][l].rem  = '0;
      dv_d[0][l].den  = zsel[l][tcp_pkg::ZW-1] ? tcp_pkg::ZW'(-zsel[l])
                                               : tcp_pkg::ZW'(zsel[l]);
      dv_d[0][l].neg  = hsel[l][tcp_pkg::HW-1] ^ zsel[l][tcp_pkg::ZW-1];
      dv_d[0][l].zero = (zsel[l] == '0);
    end
    for (int k = 0; k < tcp_pkg::NW; k++) begin
      for (int l = 0; l < tcp_pkg::Lanes; l++) begin
        logic [tcp_pkg::ZW:0] trial;
        logic                 ge;
        trial = {dv_q[k][l].rem, dv_q[k][l].num[tcp_pkg::NW-1]};
        ge    = (trial >= {1'b0, dv_q[k][l].den});
        dv_d[k+1][l]      = dv_q[k][l];
        dv_d[k+1][l].rem  = ge ? tcp_pkg::ZW'(trial - {1'b0, dv_q[k][l].den})
                               : tcp_pkg::ZW'(trial);
        dv_d[k+1][l].num  = {dv_q[k][l].num[tcp_pkg::NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= tcp_pkg::NW; k++) begin
        dv_q[k] <= dv_d[k];
      end
      dcx_q[0] <= cenx_q;
      dcy_q[0] <= ceny_q;
      for (int k = 0; k < tcp_pkg::NW; k++) begin
        dcx_q[k+1] <= dcx_q[k];
        dcy_q[k+1] <= dcy_q[k];
      end
    end
  end

  // output stage: sign, saturation, degenerate case
  always_comb begin
    for (int l = 0; l < tcp_pkg::Lanes; l++) begin
      logic signed [tcp_pkg::QXW-1:0] v;
      v = dv_q[tcp_pkg::NW][l].neg ? -tcp_pkg::QXW'(dv_q[tcp_pkg::NW][l].num)
                                   : tcp_pkg::QXW'(dv_q[tcp_pkg::NW][l].num);
      if (dv_q[tcp_pkg::NW][l].zero) begin
        pt_d[l] = '0;
      end else if (v > tcp_pkg::PtMax) begin
        pt_d[l] = tcp_pkg::PtW'(tcp_pkg::PtMax);
      end else if (v < tcp_pkg::PtMin) begin
        pt_d[l] = tcp_pkg::PtW'(tcp_pkg::PtMin);
      end else begin
        pt_d[l] = tcp_pkg::PtW'(v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q         <= pt_d;
      zero_q       <= dv_q[tcp_pkg::NW][tcp_pkg::LaneOx].zero;
      centroid_x_o <= dcx_q[tcp_pkg::NW];
      centroid_y_o <= dcy_q[tcp_pkg::NW];
    end
  end

  assign out_valid_o    = vo_q;
  assign ortho_x_o      = pt_q[tcp_pkg::LaneOx];
  assign ortho_y_o      = pt_q[tcp_pkg::LaneOy];
  assign circum_x_o     = pt_q[tcp_pkg::LaneCx];
  assign circum_y_o     = pt_q[tcp_pkg::LaneCy];
  assign ortho_valid_o  = ~zero_q;
  assign circum_valid_o = ~zero_q;

endmodule

>>> hw/rtl/tcp_checker.sv
// port-level checks of the triangle centre point block, bound to its top level
// depends on tcp_pkg and assert_macros.svh
`include "assert_macros.svh"

module tcp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [tcp_pkg::PtW-1:0]  ortho_x_o,
  input logic signed [tcp_pkg::PtW-1:0]  ortho_y_o,
  input logic                            ortho_valid_o,
  input logic signed [tcp_pkg::PtW-1:0]  circum_x_o,
  input logic                            circum_valid_o
);

  `TCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ortho_x_o), "result dropped or changed while stalled")
  `TCP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `TCP_ASSERT(a_degen_zero, clk_i, rst_ni, (out_valid_o && !ortho_valid_o) |-> (ortho_x_o == '0 && ortho_y_o == '0 && circum_x_o == '0), "degenerate transaction with non-zero point")
  `TCP_ASSERT(a_valid_agree, clk_i, rst_ni, out_valid_o |-> (ortho_valid_o == circum_valid_o), "orthocentre and circumcentre validity differ")

endmodule

bind triangle_center_points_top tcp_checker u_tcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ortho_x_o      (ortho_x_o),
  .ortho_y_o      (ortho_y_o),
  .ortho_valid_o  (ortho_valid_o),
  .circum_x_o     (circum_x_o),
  .circum_valid_o (circum_valid_o)
);
